// File: rtl/core/svpt_pkg.sv
// ----------------------------------------------------------------------------
// svpt_pkg
// Shared constants for the sextic via-point trajectory generator: default
// widths, fixed-point positions, register map and polynomial weights.
// ----------------------------------------------------------------------------
`default_nettype none

package svpt_pkg;

   // default parameter values
   localparam int COORD_WIDTH_DEF = 16;
   localparam int TIME_FRAC_DEF   = 16;

   // fixed-point positions
   localparam int ACC_POINT   = 30;   // accumulator fraction bits + time fraction bits
   localparam int RECIP_POINT = 32;   // fraction bits of inv_duration

   // field widths
   localparam int TIME_W = 16;
   localparam int INV_W  = 33;
   localparam int AXES   = 3;

   // Horner chain: c6, c5, c4, c3 then three plain multiplies by s
   localparam int HORNER_STEPS = 6;

   // polynomial weights on dx1 (mid - start) and dx2 (end - start)
   localparam int C3_DX1 = 64;
   localparam int C3_DX2 = 22;
   localparam int C4_DX1 = 192;
   localparam int C4_DX2 = 81;
   localparam int C5_DX1 = 192;
   localparam int C5_DX2 = 90;
   localparam int C6_DX1 = 64;
   localparam int C6_DX2 = 32;

   // register port
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;
   localparam int REG_SHIFT  = 3;
   localparam int REG_IDX_W  = CSR_ADDR_W - REG_SHIFT;

   localparam logic [REG_IDX_W-1:0] REG_START_POINT  = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_MID_POINT    = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_END_POINT    = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_DURATION     = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_INV_DURATION = 3'd4;

   localparam logic [TIME_W-1:0] DURATION_RST     = 16'hFFFF;
   localparam logic [INV_W-1:0]  INV_DURATION_RST = 33'd65537;

endpackage

`default_nettype wire

// File: rtl/core/sextic_via_point_trajectory.sv
// ----------------------------------------------------------------------------
// sextic_via_point_trajectory
// Sixth-order rest-to-rest trajectory through a via point, three axes.
//
//   channel  ports                      direction  handshake
//   request  start, busy, req_*         in/out     start & !busy
//   result   rsp_valid, rsp_pos_*       out        one-cycle strobe
//   csr      csr_p*                     in/out     APB write, pready high
//
// One request per cycle. A result strobes once its request has passed the
// whole pipeline: time is normalized (clamp, 16x33 multiply, round/clamp),
// the six Horner multiplies by s follow (multiply stage plus round/add
// stage each), and a last stage rounds and saturates. Synchronous reset
// empties the pipeline and loads the register defaults. busy stays low;
// results cannot be held off.
// ----------------------------------------------------------------------------
`default_nettype none

module sextic_via_point_trajectory #(
   parameter int COORD_WIDTH    = svpt_pkg::COORD_WIDTH_DEF,
   parameter int TIME_FRAC_BITS = svpt_pkg::TIME_FRAC_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   start,
   output logic                                        busy,
   input  wire logic        [svpt_pkg::TIME_W-1:0]     req_time_tick,
   output logic                                        rsp_valid,
   output logic signed      [COORD_WIDTH-1:0]          rsp_pos_x,
   output logic signed      [COORD_WIDTH-1:0]          rsp_pos_y,
   output logic signed      [COORD_WIDTH-1:0]          rsp_pos_z,
   input  wire logic                                   csr_psel,
   input  wire logic                                   csr_penable,
   input  wire logic                                   csr_pwrite,
   input  wire logic        [svpt_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic        [svpt_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic             [svpt_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                        csr_pready
);

   localparam int AXES    = svpt_pkg::AXES;
   localparam int PT_W    = AXES * COORD_WIDTH;
   localparam int COEF_W  = COORD_WIDTH + 11;
   localparam int S_W     = TIME_FRAC_BITS + 1;
   localparam int TIME_W  = svpt_pkg::TIME_W;
   localparam int INV_W   = svpt_pkg::INV_W;
   localparam int TP_W    = TIME_W + INV_W;
   localparam int SHIFT   = svpt_pkg::RECIP_POINT - TIME_FRAC_BITS;
   localparam int SQ_W    = TP_W - SHIFT;
   localparam int DATA_W  = svpt_pkg::CSR_DATA_W;

   localparam logic [TP_W-1:0] HALF_T = TP_W'(1) << (SHIFT - 1);
   localparam logic [SQ_W-1:0] S_ONE  = SQ_W'(1) << TIME_FRAC_BITS;

   // configuration registers
   logic [PT_W-1:0]   start_ff;
   logic [PT_W-1:0]   mid_ff;
   logic [PT_W-1:0]   end_ff;
   logic [TIME_W-1:0] dur_ff;
   logic [INV_W-1:0]  inv_ff;

   logic                            csr_wr;
   logic [svpt_pkg::REG_IDX_W-1:0]  csr_idx;

   // derived coefficients
   logic signed [COEF_W-1:0]      c3_in [AXES];
   logic signed [COEF_W-1:0]      c4_in [AXES];
   logic signed [COEF_W-1:0]      c5_in [AXES];
   logic signed [COEF_W-1:0]      c6_in [AXES];
   logic signed [COORD_WIDTH-1:0] p0_in [AXES];
   logic signed [COEF_W-1:0]      c3_ff [AXES];
   logic signed [COEF_W-1:0]      c4_ff [AXES];
   logic signed [COEF_W-1:0]      c5_ff [AXES];
   logic signed [COEF_W-1:0]      c6_ff [AXES];
   logic signed [COORD_WIDTH-1:0] p0_ff [AXES];

   // time normalization pipeline
   logic              accept;
   logic              va_ff;
   logic              vb_ff;
   logic              vc_ff;
   logic              ea_ff;
   logic              eb_ff;
   logic [TIME_W-1:0] ta_ff;
   logic [TP_W-1:0]   tp_ff;
   logic [TP_W-1:0]   tp_rnd;
   logic [SQ_W-1:0]   sq;
   logic [S_W-1:0]    s_in;
   logic [S_W-1:0]    s_ff;

   logic                          out_valid;
   logic signed [COORD_WIDTH-1:0] out_pos [AXES];

   assign busy       = 1'b0;
   assign accept     = start && !busy;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[svpt_pkg::CSR_ADDR_W-1:svpt_pkg::REG_SHIFT];

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         mid_ff   <= '0;
         end_ff   <= '0;
         dur_ff   <= svpt_pkg::DURATION_RST;
         inv_ff   <= svpt_pkg::INV_DURATION_RST;
      end else if (csr_wr) begin
         case (csr_idx)
            svpt_pkg::REG_START_POINT:  start_ff <= csr_pwdata[PT_W-1:0];
            svpt_pkg::REG_MID_POINT:    mid_ff   <= csr_pwdata[PT_W-1:0];
            svpt_pkg::REG_END_POINT:    end_ff   <= csr_pwdata[PT_W-1:0];
            svpt_pkg::REG_DURATION:     dur_ff   <= csr_pwdata[TIME_W-1:0];
            svpt_pkg::REG_INV_DURATION: inv_ff   <= csr_pwdata[INV_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         svpt_pkg::REG_START_POINT:  csr_prdata = DATA_W'(start_ff);
         svpt_pkg::REG_MID_POINT:    csr_prdata = DATA_W'(mid_ff);
         svpt_pkg::REG_END_POINT:    csr_prdata = DATA_W'(end_ff);
         svpt_pkg::REG_DURATION:     csr_prdata = DATA_W'(dur_ff);
         svpt_pkg::REG_INV_DURATION: csr_prdata = DATA_W'(inv_ff);
         default:                    csr_prdata = '0;
      endcase
   end

   // polynomial coefficients per axis, refreshed from the registers
   always_comb begin
      logic signed [COEF_W-1:0] p0_e;
      logic signed [COEF_W-1:0] dx1;
      logic signed [COEF_W-1:0] dx2;
      for (int l = 0; l < AXES; l++) begin
         p0_in[l] = $signed(start_ff[l*COORD_WIDTH +: COORD_WIDTH]);
         p0_e     = COEF_W'($signed(start_ff[l*COORD_WIDTH +: COORD_WIDTH]));
         dx1      = COEF_W'($signed(mid_ff[l*COORD_WIDTH +: COORD_WIDTH])) - p0_e;
         dx2      = COEF_W'($signed(end_ff[l*COORD_WIDTH +: COORD_WIDTH])) - p0_e;
         c3_in[l] = COEF_W'(svpt_pkg::C3_DX1 * dx1 - svpt_pkg::C3_DX2 * dx2);
         c4_in[l] = COEF_W'(svpt_pkg::C4_DX2 * dx2 - svpt_pkg::C4_DX1 * dx1);
         c5_in[l] = COEF_W'(svpt_pkg::C5_DX1 * dx1 - svpt_pkg::C5_DX2 * dx2);
         c6_in[l] = COEF_W'(svpt_pkg::C6_DX2 * dx2 - svpt_pkg::C6_DX1 * dx1);
      end
   end

   always_ff @(posedge clock) begin
      c3_ff <= c3_in;
      c4_ff <= c4_in;
      c5_ff <= c5_in;
      c6_ff <= c6_in;
      p0_ff <= p0_in;
   end

   // s = round(t * inv_duration), clamped to one
   assign tp_rnd = tp_ff + HALF_T;
   assign sq     = tp_rnd[TP_W-1:SHIFT];

   always_comb begin
      if (eb_ff || (sq > S_ONE)) begin
         s_in = S_ONE[S_W-1:0];
      end else begin
         s_in = sq[S_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         va_ff <= accept;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      ta_ff <= (req_time_tick > dur_ff) ? dur_ff : req_time_tick;
      ea_ff <= (req_time_tick >= dur_ff);
      tp_ff <= TP_W'(ta_ff) * TP_W'(inv_ff);
      eb_ff <= ea_ff;
      s_ff  <= s_in;
   end

   svpt_horner #(
      .COORD_WIDTH    (COORD_WIDTH),
      .TIME_FRAC_BITS (TIME_FRAC_BITS)
   ) u_horner (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vc_ff),
      .in_s      (s_ff),
      .coef_c3   (c3_ff),
      .coef_c4   (c4_ff),
      .coef_c5   (c5_ff),
      .coef_c6   (c6_ff),
      .point     (p0_ff),
      .out_valid (out_valid),
      .out_pos   (out_pos)
   );

   assign rsp_valid = out_valid;
   assign rsp_pos_x = out_pos[0];
   assign rsp_pos_y = out_pos[1];
   assign rsp_pos_z = out_pos[2];

`ifndef SYNTHESIS
   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result strobe right after reset");

   a_accept_reaches_s: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##3 vc_ff)
      else $error("request lost before normalization");

   a_s_in_range: assert property (@(posedge clock) disable iff (reset)
      vc_ff |-> (SQ_W'(s_ff) <= S_ONE))
      else $error("normalized time above one");

   a_end_is_one: assert property (@(posedge clock) disable iff (reset)
      vc_ff && $past(eb_ff) |-> (SQ_W'(s_ff) == S_ONE))
      else $error("end of path not mapped to s of one");
`endif

endmodule

`default_nettype wire

// File: rtl/core/svpt_horner.sv
// ----------------------------------------------------------------------------
// svpt_horner
// Three-lane pipelined Horner evaluator. Each of the six multiplies by s
// takes a multiply stage and a round/add stage; a last stage rounds to an
// integer, adds the start coordinate and saturates.
// ----------------------------------------------------------------------------
`default_nettype none

module svpt_horner #(
   parameter int COORD_WIDTH    = svpt_pkg::COORD_WIDTH_DEF,
   parameter int TIME_FRAC_BITS = svpt_pkg::TIME_FRAC_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 in_valid,
   input  wire logic        [TIME_FRAC_BITS:0]       in_s,
   input  wire logic signed [COORD_WIDTH+10:0]       coef_c3 [svpt_pkg::AXES],
   input  wire logic signed [COORD_WIDTH+10:0]       coef_c4 [svpt_pkg::AXES],
   input  wire logic signed [COORD_WIDTH+10:0]       coef_c5 [svpt_pkg::AXES],
   input  wire logic signed [COORD_WIDTH+10:0]       coef_c6 [svpt_pkg::AXES],
   input  wire logic signed [COORD_WIDTH-1:0]        point   [svpt_pkg::AXES],
   output logic                                      out_valid,
   output logic signed      [COORD_WIDTH-1:0]        out_pos [svpt_pkg::AXES]
);

   localparam int HFRAC  = svpt_pkg::ACC_POINT - TIME_FRAC_BITS;
   localparam int COEF_W = COORD_WIDTH + 11;
   localparam int ACC_W  = COORD_WIDTH + 12 + HFRAC;
   localparam int S_W    = TIME_FRAC_BITS + 1;
   localparam int PROD_W = ACC_W + S_W + 1;
   localparam int INT_W  = ACC_W - HFRAC;
   localparam int STEPS  = svpt_pkg::HORNER_STEPS;
   localparam int AXES   = svpt_pkg::AXES;

   localparam logic signed [PROD_W-1:0] HALF_S  = PROD_W'(1) <<< (TIME_FRAC_BITS - 1);
   localparam logic signed [ACC_W-1:0]  HALF_H  = ACC_W'(1) <<< (HFRAC - 1);
   localparam logic signed [INT_W-1:0]  POS_MAX = INT_W'((2 ** (COORD_WIDTH - 1)) - 1);
   localparam logic signed [INT_W-1:0]  POS_MIN = INT_W'(-(2 ** (COORD_WIDTH - 1)));

   logic [STEPS-1:0] mv_in;
   logic [STEPS-1:0] mv_ff;
   logic [STEPS-1:0] av_ff;
   logic             out_v_ff;

   logic [S_W-1:0] ms_in [STEPS];
   logic [S_W-1:0] ms_ff [STEPS-1];
   logic [S_W-1:0] as_ff [STEPS-1];

   logic signed [PROD_W-1:0] prod_in [AXES][STEPS];
   logic signed [PROD_W-1:0] prod_ff [AXES][STEPS];
   logic signed [ACC_W-1:0]  acc_in  [AXES][STEPS];
   logic signed [ACC_W-1:0]  acc_ff  [AXES][STEPS];

   logic signed [COORD_WIDTH-1:0] pos_in [AXES];
   logic signed [COORD_WIDTH-1:0] pos_ff [AXES];

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      if (k == 0) begin : g_first
         assign mv_in[k] = in_valid;
         assign ms_in[k] = in_s;
      end else begin : g_next
         assign mv_in[k] = av_ff[k-1];
         assign ms_in[k] = as_ff[k-1];
      end

      for (genvar l = 0; l < AXES; l++) begin : g_lane
         logic signed [ACC_W-1:0]  mul_a;
         logic signed [ACC_W-1:0]  add_c;
         logic signed [PROD_W-1:0] rnd;

         if (k == 0) begin : g_seed
            assign mul_a = {coef_c6[l][COEF_W-1], coef_c6[l], {HFRAC{1'b0}}};
         end else begin : g_chain
            assign mul_a = acc_ff[l][k-1];
         end

         if (k == 0) begin : g_c5
            assign add_c = {coef_c5[l][COEF_W-1], coef_c5[l], {HFRAC{1'b0}}};
         end else if (k == 1) begin : g_c4
            assign add_c = {coef_c4[l][COEF_W-1], coef_c4[l], {HFRAC{1'b0}}};
         end else if (k == 2) begin : g_c3
            assign add_c = {coef_c3[l][COEF_W-1], coef_c3[l], {HFRAC{1'b0}}};
         end else begin : g_none
            assign add_c = '0;
         end

         assign prod_in[l][k] = mul_a * $signed({1'b0, ms_in[k]});
         assign rnd           = prod_ff[l][k] + HALF_S;
         assign acc_in[l][k]  = $signed(rnd[TIME_FRAC_BITS +: ACC_W]) + add_c;
      end
   end

   // final round, offset and saturation
   always_comb begin
      logic signed [ACC_W-1:0] rnd_h;
      logic signed [INT_W-1:0] sum;
      for (int l = 0; l < AXES; l++) begin
         rnd_h = acc_ff[l][STEPS-1] + HALF_H;
         sum   = $signed(rnd_h[ACC_W-1:HFRAC]) + INT_W'(point[l]);
         if (sum > POS_MAX) begin
            pos_in[l] = POS_MAX[COORD_WIDTH-1:0];
         end else if (sum < POS_MIN) begin
            pos_in[l] = POS_MIN[COORD_WIDTH-1:0];
         end else begin
            pos_in[l] = sum[COORD_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mv_ff    <= '0;
         av_ff    <= '0;
         out_v_ff <= 1'b0;
      end else begin
         mv_ff    <= mv_in;
         av_ff    <= mv_ff;
         out_v_ff <= av_ff[STEPS-1];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < STEPS - 1; k++) begin
         ms_ff[k] <= ms_in[k];
         as_ff[k] <= ms_ff[k];
      end
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      pos_ff  <= pos_in;
   end

   assign out_valid = out_v_ff;
   assign out_pos   = pos_ff;

endmodule

`default_nettype wire
